/* hw/rtl/mss_pkg.sv */
// Shared types and constants for the MIDI step sequencer.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package mss_pkg;

  // Request codes carried on the input tuser.
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_TOGGLE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // Event codes carried on the output tuser.
  localparam logic [1:0] KIND_ON    = 2'd0;
  localparam logic [1:0] KIND_OFF   = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [1:0] REG_SAMPLES_PER_STEP = 2'd0;
  localparam logic [1:0] REG_CURRENT_PATTERN  = 2'd1;
  localparam logic [1:0] REG_PLAY_ENABLE      = 2'd2;

  localparam logic [19:0] SAMPLES_PER_STEP_RESET = 20'd5512;

  // One pattern store entry.
  typedef struct packed {
    logic       active;
    logic [6:0] note;
    logic [6:0] velocity;
  } entry_t;

  // One result word waiting for the output side.
  typedef struct packed {
    logic [1:0] event_kind;
    logic [6:0] out_note;
    logic [6:0] out_velocity;
    logic       step_active;
    logic       last_result;
  } result_t;

  // Configuration register contents.
  typedef struct packed {
    logic [19:0] samples_per_step;
    logic [2:0]  current_pattern;
    logic        play_enable;
  } cfg_t;

endpackage

/* hw/rtl/mss_cfg.sv */
// APB-style register block of the step sequencer.
// Depends on mss_pkg for register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module mss_cfg import mss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr_en;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.samples_per_step <= SAMPLES_PER_STEP_RESET;
      cfg.current_pattern  <= 3'd0;
      cfg.play_enable      <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_SAMPLES_PER_STEP: cfg.samples_per_step <= pwdata[19:0];
        REG_CURRENT_PATTERN:  cfg.current_pattern  <= pwdata[2:0];
        REG_PLAY_ENABLE:      cfg.play_enable      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_SAMPLES_PER_STEP: prdata = {12'd0, cfg.samples_per_step};
      REG_CURRENT_PATTERN:  prdata = {29'd0, cfg.current_pattern};
      REG_PLAY_ENABLE:      prdata = {31'd0, cfg.play_enable};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

/* hw/rtl/mss_store.sv */
// Pattern store: single-port-write, registered-read memory with a
// clearing sweep after reset and write-to-read forwarding. Uses mss_pkg.
`timescale 1ns / 1ps

module mss_store import mss_pkg::*; #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  output entry_t        rdata,
  output logic          busy
);

  entry_t        mem [DEPTH];
  entry_t        rq;
  entry_t        byp_data;
  logic          byp;
  logic [AW-1:0] clr_addr;

  // Clearing sweep, one entry per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rq       <= mem[raddr];
      byp      <= we && !busy && (waddr == raddr);
      byp_data <= wdata;
    end
  end

  // A read that collided with a write sees the new data.
  assign rdata = byp ? byp_data : rq;

endmodule

/* hw/rtl/mss_fifo.sv */
// Four-word result queue that takes up to two words per cycle and
// hands out one while out_ready is high. Uses mss_pkg for result_t.
`timescale 1ns / 1ps

module mss_fifo import mss_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_n,
  input  result_t    push0,
  input  result_t    push1,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_word
);

  result_t    slots [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 3'd0);
  assign out_word  = slots[rp];
  // Room for the worst case of two words from one item.
  assign room      = (count <= 3'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + push_n;
      rp    <= rp + {1'b0, pop};
      count <= count + {1'b0, push_n} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      slots[wp] <= push0;
    end
    if (push_n == 2'd2) begin
      slots[wp + 2'd1] <= push1;
    end
  end

endmodule

/* hw/rtl/midi_step_sequencer.sv */
// Pipeline: a request word is registered into stage two, which fills the output queue.
// Throughput: one request word per cycle; s_tready drops while stage two is full and the
// result queue holds more than two words, so requests that each make two words are paced
// by the one-word output.
// Reset: synchronous; the pattern store is cleared by a sweep over its PATTERNS*STEPS
// entries after reset, during which s_tready stays low (configuration writes still work).
`timescale 1ns / 1ps

// Top level of the pattern step sequencer.
// Depends on mss_pkg, mss_cfg, mss_store and mss_fifo.
module midi_step_sequencer import mss_pkg::*; #(
  parameter int STEPS    = 16,
  parameter int PATTERNS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Request stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata, low bit up: step_number[3:0], pattern_number[6:4], note_number[13:7],
  // note_velocity[20:14], zero padding[23:21].
  input  logic [23:0] s_tdata,
  // tuser: req_type[1:0].
  input  logic [1:0]  s_tuser,
  // Event stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata, low bit up: out_note[6:0], out_velocity[13:7], step_active[14], zero[15].
  output logic [15:0] m_tdata,
  // tuser: event_kind[1:0].
  output logic [1:0]  m_tuser,
  // tlast: last_result.
  output logic        m_tlast,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = STEPS * PATTERNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(STEPS);

  // Work that the second stage does for one request.
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_TICK,
    OP_TICK_STEP,
    OP_TOGGLE,
    OP_QUERY,
    OP_QUERY_NULL
  } op_t;

  cfg_t cfg;

  mss_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ------------------------------------------------------------------
  // Stage one: decode the request, advance the step clock and address
  // the pattern store. The tick counter and the step position depend on
  // nothing in the store, so they move as soon as a tick is taken.
  // ------------------------------------------------------------------
  logic [3:0]    step_number;
  logic [2:0]    pattern_number;
  logic [6:0]    note_number;
  logic [6:0]    note_velocity;

  assign step_number    = s_tdata[3:0];
  assign pattern_number = s_tdata[6:4];
  assign note_number    = s_tdata[13:7];
  assign note_velocity  = s_tdata[20:14];

  logic [19:0]   tick_count;
  logic [SW-1:0] step_position;
  logic [20:0]   tick_sum;
  logic          boundary;
  logic [SW-1:0] step_next;
  logic [2:0]    live_pat;
  logic          step_ok;
  logic          pat_ok;
  op_t           op_in;
  logic [AW-1:0] addr_in;
  logic          accept;
  logic          store_busy;

  assign tick_sum  = {1'b0, tick_count} + 21'd1;
  // A period lowered below the count, or zero, reaches the boundary at once.
  assign boundary  = (tick_sum >= {1'b0, cfg.samples_per_step});
  assign step_next = (step_position == SW'(STEPS - 1)) ? '0 : step_position + 1'b1;
  // A pattern register beyond the store saturates to the last pattern.
  assign live_pat  = (32'(cfg.current_pattern) >= PATTERNS) ? 3'(PATTERNS - 1)
                                                            : cfg.current_pattern;
  assign step_ok   = (32'(step_number) < STEPS);
  assign pat_ok    = (32'(pattern_number) < PATTERNS);

  always_comb begin
    op_in   = OP_IDLE;
    addr_in = '0;
    unique case (s_tuser)
      REQ_TICK: begin
        if (cfg.play_enable) begin
          op_in   = boundary ? OP_TICK_STEP : OP_TICK;
          addr_in = AW'(32'(live_pat) * STEPS + 32'(step_next));
        end
      end
      REQ_TOGGLE: begin
        if (step_ok) begin
          op_in   = OP_TOGGLE;
          addr_in = AW'(32'(live_pat) * STEPS + 32'(step_number));
        end
      end
      REQ_QUERY: begin
        if (step_ok && pat_ok) begin
          op_in   = OP_QUERY;
          addr_in = AW'(32'(pattern_number) * STEPS + 32'(step_number));
        end else begin
          op_in   = OP_QUERY_NULL;
        end
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------------
  // Stage two registers and handshake.
  // ------------------------------------------------------------------
  logic          s2_valid;
  op_t           s2_op;
  logic [6:0]    s2_note;
  logic [6:0]    s2_velocity;
  logic [AW-1:0] s2_addr;
  logic          s2_fire;
  logic          fifo_room;

  // The item in stage two leaves once the queue can hold both of its words;
  // a new request may enter in the same cycle.
  assign s2_fire  = s2_valid && fifo_room;
  assign s_tready = !store_busy && (!s2_valid || fifo_room);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid      <= 1'b0;
      tick_count    <= '0;
      step_position <= '0;
    end else begin
      if (accept) begin
        s2_valid <= 1'b1;
      end else if (s2_fire) begin
        s2_valid <= 1'b0;
      end
      if (accept && s_tuser == REQ_TICK && cfg.play_enable) begin
        if (boundary) begin
          tick_count    <= '0;
          step_position <= step_next;
        end else begin
          tick_count    <= tick_sum[19:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_op       <= op_in;
      s2_note     <= note_number;
      s2_velocity <= note_velocity;
      s2_addr     <= addr_in;
    end
  end

  // ------------------------------------------------------------------
  // Pattern store. The entry read at acceptance is ready in stage two;
  // a toggle written there is forwarded to the read issued in that cycle.
  // ------------------------------------------------------------------
  entry_t entry;
  entry_t wr_entry;
  logic   wr_en;

  always_comb begin
    if (entry.active && entry.note == s2_note) begin
      wr_entry        = entry;
      wr_entry.active = 1'b0;
    end else begin
      wr_entry.active   = 1'b1;
      wr_entry.note     = s2_note;
      wr_entry.velocity = s2_velocity;
    end
  end

  assign wr_en = s2_fire && (s2_op == OP_TOGGLE);

  mss_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .re    (accept),
    .raddr (addr_in),
    .we    (wr_en),
    .waddr (s2_addr),
    .wdata (wr_entry),
    .rdata (entry),
    .busy  (store_busy)
  );

  // ------------------------------------------------------------------
  // Stage two: release countdown, note events and query reports.
  // The pending note-off is handled before the step boundary, so at most
  // one note-off and one note-on come from a single tick.
  // ------------------------------------------------------------------
  logic        sounding_valid;
  logic [6:0]  sounding_note;
  logic [19:0] release_countdown;

  logic        is_tick;
  logic        release_now;
  logic        held;
  logic        note_on;
  logic        note_off;
  logic        sounding_valid_next;
  logic [6:0]  sounding_note_next;
  logic [19:0] release_countdown_next;
  result_t     off_word;
  result_t     on_word;
  result_t     push0;
  result_t     push1;
  logic [1:0]  push_n;

  assign is_tick     = (s2_op == OP_TICK) || (s2_op == OP_TICK_STEP);
  assign release_now = sounding_valid && (release_countdown <= 20'd1);
  assign held        = sounding_valid && !release_now;
  assign note_on     = (s2_op == OP_TICK_STEP) && entry.active;
  // Either the timed release fires, or a new note cuts off the held one.
  assign note_off    = release_now || (note_on && held);

  always_comb begin
    sounding_valid_next    = held;
    sounding_note_next     = sounding_note;
    release_countdown_next = release_now ? 20'd0
                           : (sounding_valid ? release_countdown - 20'd1 : release_countdown);
    if (note_on) begin
      sounding_valid_next    = 1'b1;
      sounding_note_next     = entry.note;
      release_countdown_next = cfg.samples_per_step >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sounding_valid    <= 1'b0;
      sounding_note     <= '0;
      release_countdown <= '0;
    end else if (s2_fire && is_tick) begin
      sounding_valid    <= sounding_valid_next;
      sounding_note     <= sounding_note_next;
      release_countdown <= release_countdown_next;
    end
  end

  always_comb begin
    off_word = '{event_kind: KIND_OFF, out_note: sounding_note, out_velocity: 7'd0,
                 step_active: 1'b0, last_result: !note_on};
    on_word  = '{event_kind: KIND_ON, out_note: entry.note, out_velocity: entry.velocity,
                 step_active: 1'b0, last_result: 1'b1};
    push0    = on_word;
    push1    = on_word;
    push_n   = 2'd0;
    unique case (s2_op)
      OP_TICK, OP_TICK_STEP: begin
        if (note_off) begin
          push0  = off_word;
          push_n = note_on ? 2'd2 : 2'd1;
        end else if (note_on) begin
          push_n = 2'd1;
        end
      end
      OP_QUERY: begin
        push0  = '{event_kind: KIND_QUERY, out_note: entry.note,
                   out_velocity: entry.velocity, step_active: entry.active,
                   last_result: 1'b1};
        push_n = 2'd1;
      end
      OP_QUERY_NULL: begin
        push0  = '{event_kind: KIND_QUERY, out_note: 7'd0, out_velocity: 7'd0,
                   step_active: 1'b0, last_result: 1'b1};
        push_n = 2'd1;
      end
      default: ;
    endcase
    if (!s2_fire) begin
      push_n = 2'd0;
    end
  end

  // ------------------------------------------------------------------
  // Output queue and master side.
  // ------------------------------------------------------------------
  result_t out_word;

  mss_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push0     (push0),
    .push1     (push1),
    .room      (fifo_room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (out_word)
  );

  assign m_tdata = {1'b0, out_word.step_active, out_word.out_velocity, out_word.out_note};
  assign m_tuser = out_word.event_kind;
  assign m_tlast = out_word.last_result;

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    store_busy |-> !s_tready)
    else $error("request taken while the pattern store is being cleared");

  a_step_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser != REQ_TICK) |=> $stable(step_position))
    else $error("step position moved on a toggle or query");

  a_note_on_sounds: assert property (@(posedge clk) disable iff (rst)
    (s2_fire && note_on) |=> sounding_valid)
    else $error("note-on sent without a sounding note");

  a_off_needs_sounding: assert property (@(posedge clk) disable iff (rst)
    (s2_fire && is_tick && note_off) |-> sounding_valid)
    else $error("note-off sent with no note sounding");

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the MIDI step sequencer: request and event streams plus
// the configuration port. Depends on mss_pkg and the midi_step_sequencer top level.
`timescale 1ns / 1ps

module tb import mss_pkg::*; ();

  localparam int STEPS    = 16;
  localparam int PATTERNS = 8;

  // Request code the block does not use; it must be swallowed without an event.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Cycles with no word moving on either stream before the run is declared hung.
  // The limit lies well above the clearing sweep after reset, the receiver's longest stall
  // pattern and the short sender gaps.
  localparam int HANG_LIMIT = 3000;

  // Cycles to let pass after the last event before touching the registers. Toggles and
  // ticks that cause no event may still be in flight in the block after the last event.
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [1:0] req;
    logic [3:0] step;
    logic [2:0] pat;
    logic [6:0] note;
    logic [6:0] vel;
  } req_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  midi_step_sequencer #(
    .STEPS(STEPS),
    .PATTERNS(PATTERNS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // Request words waiting to be sent, and the events they are predicted to cause.
  req_word_t request_q[$];
  result_t   event_q[$];
  int        n_queued = 0;
  int        n_accepted = 0;
  int        mismatches = 0;

  // Shadow copy of the sequencer: pattern store, playback state and registers.
  entry_t      pattern_mem [PATTERNS*STEPS];
  int          play_step = 0;
  logic [19:0] tick_cnt = '0;
  logic        sounding = 1'b0;
  logic [6:0]  sound_note = '0;
  logic [19:0] release_cnt = '0;
  logic [19:0] cfg_spp = SAMPLES_PER_STEP_RESET;
  logic [2:0]  cfg_pat = '0;
  logic        cfg_play = 1'b0;

  initial begin
    for (int i = 0; i < PATTERNS*STEPS; i++) begin
      pattern_mem[i] = '0;
    end
  end

  function automatic result_t make_event(logic [1:0] kind, logic [6:0] note,
                                         logic [6:0] vel, logic act);
    result_t r;
    r.event_kind   = kind;
    r.out_note     = note;
    r.out_velocity = vel;
    r.step_active  = act;
    r.last_result  = 1'b0;
    return r;
  endfunction

  function automatic req_word_t make_req(logic [1:0] req, int step, int pat, int note, int vel);
    req_word_t w;
    w.req  = req;
    w.step = step[3:0];
    w.pat  = pat[2:0];
    w.note = note[6:0];
    w.vel  = vel[6:0];
    return w;
  endfunction

  // Applies one accepted request word to the shadow state and queues the events it
  // causes, with tlast on the final one.
  task automatic predict_events(input req_word_t w);
    result_t ev [2];
    int      n;
    int      idx;
    entry_t  e;
    n = 0;
    case (w.req)
      REQ_TICK: begin
        if (cfg_play) begin
          // The pending release is serviced before the step counter moves.
          if (sounding) begin
            if (release_cnt <= 20'd1) begin
              ev[n] = make_event(KIND_OFF, sound_note, 7'd0, 1'b0);
              n++;
              sounding = 1'b0;
              release_cnt = '0;
            end else begin
              release_cnt = release_cnt - 20'd1;
            end
          end
          tick_cnt = tick_cnt + 20'd1;
          // A period lowered below the count, or set to zero, trips at once.
          if (tick_cnt >= cfg_spp) begin
            tick_cnt = '0;
            play_step = (play_step + 1) % STEPS;
            e = pattern_mem[int'(cfg_pat) * STEPS + play_step];
            if (e.active) begin
              // A note still held from the previous step is cut off first.
              if (sounding) begin
                ev[n] = make_event(KIND_OFF, sound_note, 7'd0, 1'b0);
                n++;
              end
              ev[n] = make_event(KIND_ON, e.note, e.velocity, 1'b0);
              n++;
              sounding = 1'b1;
              sound_note = e.note;
              release_cnt = cfg_spp >> 1;
            end
          end
        end
      end
      REQ_TOGGLE: begin
        idx = int'(cfg_pat) * STEPS + int'(w.step);
        e = pattern_mem[idx];
        // Same note on an active step switches it off but keeps note and velocity.
        if (e.active && e.note == w.note) begin
          e.active = 1'b0;
        end else begin
          e.active = 1'b1;
          e.note = w.note;
          e.velocity = w.vel;
        end
        pattern_mem[idx] = e;
      end
      REQ_QUERY: begin
        e = pattern_mem[int'(w.pat) * STEPS + int'(w.step)];
        ev[n] = make_event(KIND_QUERY, e.note, e.velocity, e.active);
        n++;
      end
      default: begin
      end
    endcase
    if (n > 0) begin
      ev[n-1].last_result = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      event_q.push_back(ev[i]);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  // Request driver. It sends words in bursts of random length, with random gaps between
  // bursts; a gap of zero joins two bursts into a long unbroken stretch.
  int        burst_left = 1;
  int        gap_left = 0;
  req_word_t cur_req = '0;

  always @(posedge clk) begin : drive_requests
    logic next_valid;
    next_valid = s_tvalid;
    if (rst) begin
      next_valid = 1'b0;
      burst_left = 1;
      gap_left = 0;
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_events(cur_req);
        n_accepted++;
      end
      // Load a new word only when the bus is free or the current word was taken.
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          next_valid = 1'b0;
        end else if (request_q.size() > 0) begin
          cur_req = request_q.pop_front();
          next_valid = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          next_valid = 1'b0;
        end
        s_tvalid <= next_valid;
        s_tdata  <= {3'b000, cur_req.vel, cur_req.note, cur_req.pat, cur_req.step};
        s_tuser  <= cur_req.req;
      end
    end
  end

  // Event monitor. The receiver keeps changing between four stall patterns, each picked at random:
  // always ready, coin flip, one cycle in four, and short windows between long stalls.
  int rx_cycle = 0;
  int rx_mode = 0;

  always @(posedge clk) begin : watch_events
    result_t want;
    logic    ready_next;
    if (!rst && m_tvalid && m_tready) begin
      if (event_q.size() == 0) begin
        report_mismatch($sformatf("event word with nothing expected: kind %0d note %0d",
                                  m_tuser, m_tdata[6:0]));
      end else begin
        want = event_q.pop_front();
        check_field("event_kind", int'(m_tuser), int'(want.event_kind));
        check_field("out_note", int'(m_tdata[6:0]), int'(want.out_note));
        check_field("out_velocity", int'(m_tdata[13:7]), int'(want.out_velocity));
        check_field("step_active", int'(m_tdata[14]), int'(want.step_active));
        check_field("last_result", int'(m_tlast), int'(want.last_result));
      end
    end
    rx_cycle++;
    if (rx_cycle % 100 == 0) begin
      rx_mode = $urandom_range(3);
    end
    case (rx_mode)
      0: ready_next = 1'b1;
      1: ready_next = 1'($urandom_range(1));
      2: ready_next = ($urandom_range(3) == 0);
      default: ready_next = (rx_cycle % 48) < 8;
    endcase
    m_tready <= ready_next;
  end

  // Hang detection: counts cycles in which no word moves on either stream.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One write on the configuration port: setup cycle, then access cycle. The shadow
  // registers change at the edge where the block takes the write.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_SAMPLES_PER_STEP: cfg_spp = value[19:0];
      REG_CURRENT_PATTERN:  cfg_pat = value[2:0];
      REG_PLAY_ENABLE:      cfg_play = value[0];
      default: begin
      end
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send(input req_word_t w);
    request_q.push_back(w);
    n_queued++;
  endtask

  task automatic send_ticks(input int count);
    for (int i = 0; i < count; i++) begin
      send(make_req(REQ_TICK, 0, 0, 0, 0));
    end
  endtask

  // Holds the sender until every word is taken and every event has come back, then
  // lets the block settle so that a register write cannot land on work in flight.
  task automatic wait_idle();
    while (!(n_accepted == n_queued && event_q.size() == 0)) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int          spp_plan [8];
    logic [6:0]  note_pool [4];
    int          pick;
    int          pat;
    req_word_t   w;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Editing with playback stopped, on the highest pattern.
    write_reg(REG_CURRENT_PATTERN, 32'd7);
    write_reg(REG_PLAY_ENABLE, 32'd0);
    send(make_req(REQ_QUERY, 15, 7, 0, 0));       // never written: inactive, zeros
    send(make_req(REQ_TOGGLE, 15, 0, 127, 127));
    send(make_req(REQ_QUERY, 15, 7, 0, 0));
    send(make_req(REQ_TOGGLE, 15, 0, 127, 5));    // same note switches the step off
    send(make_req(REQ_QUERY, 15, 7, 0, 0));       // inactive, old note and velocity kept
    send(make_req(REQ_TOGGLE, 15, 0, 4, 0));      // inactive step is written again
    send(make_req(REQ_TOGGLE, 15, 0, 3, 9));      // active, other note: overwritten
    send(make_req(REQ_QUERY, 15, 7, 0, 0));
    send(make_req(REQ_TOGGLE, 0, 0, 0, 127));
    send(make_req(REQ_TOGGLE, 1, 0, 60, 100));
    send(make_req(REQ_TOGGLE, 2, 0, 61, 101));
    send(make_req(REQ_TOGGLE, 3, 0, 62, 102));
    send(make_req(REQ_QUERY, 0, 0, 0, 0));        // other pattern, untouched
    send(make_req(REQ_TICK, 15, 7, 127, 127));    // ignored while stopped
    send(make_req(REQ_UNUSED, 15, 7, 127, 127));  // unused request code
    wait_idle();

    // Step 1 sounds after six ticks and its release is still three ticks away.
    write_reg(REG_SAMPLES_PER_STEP, 32'd6);
    write_reg(REG_PLAY_ENABLE, 32'd1);
    send_ticks(6);
    wait_idle();

    // A shorter period forces the next step while the note still sounds: note-off
    // then note-on from one tick. With a zero-length release it expires on the next one.
    write_reg(REG_SAMPLES_PER_STEP, 32'd1);
    send_ticks(3);
    wait_idle();

    // A zero period puts every tick on a step boundary.
    write_reg(REG_SAMPLES_PER_STEP, 32'd0);
    send_ticks(2);

    // Random phases. The period list includes both extremes, and the long period is
    // followed by a short one so that the count stands past the new period.
    spp_plan = '{1, 3, 2, 0, 5, 8, 1048575, 4};
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      if (ph == 7) begin
        spp_plan[ph] = (ph == 7) ? 4 : spp_plan[ph];
      end
      write_reg(REG_SAMPLES_PER_STEP, spp_plan[ph]);
      pat = (ph == 0) ? 0 : (ph == 1) ? 7 : $urandom_range(PATTERNS - 1);
      write_reg(REG_CURRENT_PATTERN, pat);
      write_reg(REG_PLAY_ENABLE, (ph == 2) ? 0 : 1);
      // A small set of notes makes toggles hit the same note often enough to switch off.
      for (int i = 0; i < 4; i++) begin
        note_pool[i] = 7'($urandom_range(127));
      end
      for (int k = 0; k < 62; k++) begin
        pick = $urandom_range(99);
        w = make_req(REQ_TICK, $urandom_range(15), $urandom_range(7),
                     $urandom_range(127), $urandom_range(127));
        if (pick < 55) begin
          w.req = REQ_TICK;
        end else if (pick < 75) begin
          w.req = REQ_TOGGLE;
          if ($urandom_range(1) == 0) begin
            w.note = note_pool[2'($urandom_range(3))];
          end
        end else if (pick < 93) begin
          w.req = REQ_QUERY;
          if ($urandom_range(9) < 7) begin
            w.pat = pat[2:0];
          end
        end else begin
          w.req = REQ_UNUSED;
        end
        send(w);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* midi_step_sequencer.f */
hw/rtl/mss_pkg.sv
hw/rtl/mss_cfg.sv
hw/rtl/mss_store.sv
hw/rtl/mss_fifo.sv
hw/rtl/midi_step_sequencer.sv
tb/sv/tb.sv
